### sv/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types, constants and the sRGB decode table for the grid statistics.
// ----------------------------------------------------------------------------
package gls_pkg;

    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 48;
    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;

    localparam int CELL_W  = $clog2(GRID_COLUMNS);
    localparam int BAND_W  = 6;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int LIN_W   = 16;
    localparam int SUM_W   = 39;
    localparam int COUNT_W = 13;
    localparam int ENTRY_W = SUM_W + COUNT_W;
    localparam int ADDR_W  = 3;

    // Rec.709 weights in Q0.16
    localparam logic [15:0] WEIGHT_R = 16'd13933;
    localparam logic [15:0] WEIGHT_G = 16'd46871;
    localparam logic [15:0] WEIGHT_B = 16'd4732;

    // 2^23 / 255, rounded down; one correction step follows
    localparam logic [15:0] RECIP_255 = 16'd32896;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [5:0]  cell_column;
        logic [5:0]  cell_row;
        logic [15:0] mean_luma;
        logic        cell_valid;
        logic        band_last;
        logic        frame_last;
    } stats_t;

    // control that travels with a pixel down the pipeline
    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic              write;
        logic              clear;
        logic              band_end;
        logic              last_row;
        logic [BAND_W-1:0] band;
    } pix_tag_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } gls_state_t;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    function automatic logic [LIN_W-1:0] lin_entry(int unsigned i);
        longint unsigned x;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        longint unsigned s2;
        longint unsigned s4;
        longint unsigned s8;
        longint unsigned s12;
        if (i <= 10) begin
            return LIN_W'((655350 * longint'(i) + 16473) / 32946);
        end
        x  = (longint'(1000 * i + 14025) << 30) / 269025;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = (mid * mid) >> 30;
            p = (p * mid) >> 30;
            p = (p * mid) >> 30;
            p = (p * mid) >> 30;
            if (p <= x) lo = mid;
            else        hi = mid - 1;
        end
        s2  = (lo * lo) >> 30;
        s4  = (s2 * s2) >> 30;
        s8  = (s4 * s4) >> 30;
        s12 = (s8 * s4) >> 30;
        return LIN_W'((s12 * 65535 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = lin_entry(i);
        end
        return t;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

### sv/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/gls_luma_pipe.sv
// ----------------------------------------------------------------------------
// gls_luma_pipe
// Five-stage pipe: sRGB decode, luma, alpha scale, divide by 255.
// ----------------------------------------------------------------------------
module gls_luma_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gls_pkg::pixel_t   in_pixel,
    input  gls_pkg::pix_tag_t in_tag,
    output logic              out_valid,
    output gls_pkg::pix_tag_t out_tag,
    output logic [15:0]       out_scaled
);
    import gls_pkg::*;

    logic [4:0]     vld_reg;
    pix_tag_t       tag_reg [5];

    logic [15:0]    lr_reg, lg_reg, lb_reg;
    logic [7:0]     a1_reg, a2_reg;
    logic [15:0]    y_reg;
    logic [23:0]    v3_reg, v4_reg;
    logic [16:0]    q_reg;
    logic [15:0]    scaled_reg;

    logic [31:0]    luma_sum;
    logic [39:0]    recip_prod;
    logic [24:0]    rem;

    assign luma_sum = 32'(lr_reg) * 32'(WEIGHT_R) + 32'(lg_reg) * 32'(WEIGHT_G)
                    + 32'(lb_reg) * 32'(WEIGHT_B) + 32'd32768;
    assign recip_prod = 40'(v3_reg) * 40'(RECIP_255);
    assign rem = 25'(v4_reg) - 25'(q_reg) * 25'd255;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int s = 1; s < 5; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
        lr_reg     <= LIN_TABLE[in_pixel.red];
        lg_reg     <= LIN_TABLE[in_pixel.green];
        lb_reg     <= LIN_TABLE[in_pixel.blue];
        a1_reg     <= in_pixel.alpha;
        y_reg      <= luma_sum[31:16];
        a2_reg     <= a1_reg;
        v3_reg     <= 24'(y_reg) * 24'(a2_reg) + 24'd127;
        q_reg      <= recip_prod[39:23];
        v4_reg     <= v3_reg;
        scaled_reg <= (rem >= 25'd255) ? 16'(q_reg + 17'd1) : q_reg[15:0];
    end

    assign out_valid  = vld_reg[4];
    assign out_tag    = tag_reg[4];
    assign out_scaled = scaled_reg;

endmodule

### sv/grid_luma_statistics_unit.sv
// ----------------------------------------------------------------------------
// grid_luma_statistics_unit
// Per-cell luma sums of a grid row band in a 64-entry RAM, means at band end.
// ----------------------------------------------------------------------------
// Pixels: one item per cycle unless held off at band end; a same-cell update
// right after another is forwarded from the last-write register.
// Band end: input held off while the pipe drains and the 64 means are output,
// each by RAM read, load, 16-step restoring divider and output register; a
// mean waits until the receiver has taken the one before it.
// Reset: positions to 0,0, width 64, height 48, all cell valid bits cleared.
module grid_luma_statistics_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  gls_pkg::pixel_t               pixel,
    output logic                          stats_valid,
    input  logic                          stats_ready,
    output gls_pkg::stats_t               stats,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gls_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gls_pkg::*;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(GRID_COLUMNS - 1);

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             cfg_wr;

    // position tracking
    logic [POS_W-1:0]  col_reg, row_reg;
    logic [DIM_W-1:0]  cacc_reg, racc_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [BAND_W-1:0] band_reg;
    logic              accept;
    logic [POS_W-1:0]  cur_col, cur_row;
    logic [DIM_W-1:0]  cur_cacc, cur_racc;
    logic [CELL_W-1:0] cur_cell;
    logic [BAND_W-1:0] cur_band;
    logic [DIM_W:0]    cacc_sum, racc_sum;
    logic              end_col, last_row, band_end;
    pix_tag_t          in_tag;
    logic              band_pend_reg;

    // pipe and update stage
    logic              p_valid;
    pix_tag_t          p_tag;
    logic [15:0]       p_scaled;
    logic              w_valid_reg;
    pix_tag_t          w_tag_reg;
    logic [15:0]       w_scaled_reg;
    logic [GRID_COLUMNS-1:0] cvld_reg;
    logic              lw_valid_reg;
    logic [CELL_W-1:0] lw_cell_reg;
    logic [ENTRY_W-1:0] lw_data_reg;
    logic [ENTRY_W-1:0] old_entry, new_entry, rdata;
    logic              w_write;
    logic [CELL_W-1:0] raddr;

    // flush
    gls_state_t        state_reg, state_next;
    logic [CELL_W-1:0] fidx_reg;
    logic [BAND_W-1:0] fband_reg;
    logic              flast_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [COUNT_W+14:0] den_reg;
    logic [15:0]       quo_reg;
    logic [3:0]        dcnt_reg;
    logic              nz_reg;
    logic              fl_read, fl_load, fl_step, fl_out, fl_done;
    logic [ENTRY_W-1:0] fl_entry;
    logic              out_valid_reg;
    stats_t            out_reg;

    // ---------------- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(64);
            height_reg <= DIM_W'(48);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WIDTH) width_reg  <= pwdata[DIM_W-1:0];
            else                       height_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign eff_w = (width_reg < DIM_W'(GRID_COLUMNS)) ? DIM_W'(GRID_COLUMNS) :
                   (width_reg > DIM_W'(MAX_WIDTH))    ? DIM_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg < DIM_W'(GRID_ROWS))   ? DIM_W'(GRID_ROWS) :
                   (height_reg > DIM_W'(MAX_HEIGHT))  ? DIM_W'(MAX_HEIGHT) : height_reg;

    // ---------------- position and cell index
    assign pixel_ready = (state_reg == ST_RUN) && !band_pend_reg;
    assign accept      = pixel_valid && pixel_ready;

    always_comb
    begin
        if (pixel.frame_start)
        begin
            cur_col  = '0;
            cur_row  = '0;
            cur_cacc = '0;
            cur_racc = '0;
            cur_cell = '0;
            cur_band = '0;
        end
        else
        begin
            cur_col  = col_reg;
            cur_row  = row_reg;
            cur_cacc = cacc_reg;
            cur_racc = racc_reg;
            cur_cell = cell_reg;
            cur_band = band_reg;
        end
    end

    // accumulators hold x*cols - cell*w and y*rows - band*h
    assign cacc_sum = {1'b0, cur_cacc} + (DIM_W+1)'(GRID_COLUMNS);
    assign racc_sum = {1'b0, cur_racc} + (DIM_W+1)'(GRID_ROWS);
    assign end_col  = {1'b0, cur_col} == eff_w - 1'b1;
    assign last_row = {1'b0, cur_row} == eff_h - 1'b1;
    assign band_end = end_col && (last_row || racc_sum >= {1'b0, eff_h});

    always_comb
    begin
        in_tag.cell_idx = cur_cell;
        in_tag.write    = pixel.alpha != 8'd0;
        in_tag.clear    = pixel.frame_start;
        in_tag.band_end = band_end;
        in_tag.last_row = last_row;
        in_tag.band     = cur_band;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cacc_reg <= '0;
            racc_reg <= '0;
            cell_reg <= '0;
            band_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cacc_reg <= '0;
            racc_reg <= '0;
            cell_reg <= '0;
            band_reg <= '0;
        end
        else if (accept)
        begin
            if (end_col)
            begin
                col_reg  <= '0;
                cacc_reg <= '0;
                cell_reg <= '0;
                if (last_row)
                begin
                    row_reg  <= '0;
                    racc_reg <= '0;
                    band_reg <= '0;
                end
                else
                begin
                    row_reg <= cur_row + 1'b1;
                    if (racc_sum >= {1'b0, eff_h})
                    begin
                        racc_reg <= DIM_W'(racc_sum - {1'b0, eff_h});
                        band_reg <= cur_band + 1'b1;
                    end
                    else
                    begin
                        racc_reg <= racc_sum[DIM_W-1:0];
                    end
                end
            end
            else
            begin
                col_reg <= cur_col + 1'b1;
                if (cacc_sum >= {1'b0, eff_w})
                begin
                    cacc_reg <= DIM_W'(cacc_sum - {1'b0, eff_w});
                    cell_reg <= cur_cell + 1'b1;
                end
                else
                begin
                    cacc_reg <= cacc_sum[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                         band_pend_reg <= 1'b0;
        else if (accept && band_end)        band_pend_reg <= 1'b1;
        else if (fl_done)                   band_pend_reg <= 1'b0;
    end

    // ---------------- luma pipe
    gls_luma_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_pixel   (pixel),
        .in_tag     (in_tag),
        .out_valid  (p_valid),
        .out_tag    (p_tag),
        .out_scaled (p_scaled)
    );

    // ---------------- store update
    assign raddr = fl_read ? fidx_reg : p_tag.cell_idx;

    gls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GRID_COLUMNS)
    ) u_store (
        .clk   (clk),
        .we    (w_write),
        .waddr (w_tag_reg.cell_idx),
        .wdata (new_entry),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) w_valid_reg <= 1'b0;
        else        w_valid_reg <= p_valid;
    end

    always_ff @(posedge clk)
    begin
        w_tag_reg    <= p_tag;
        w_scaled_reg <= p_scaled;
    end

    assign w_write = w_valid_reg && w_tag_reg.write;

    always_comb
    begin
        if (w_tag_reg.clear || !cvld_reg[w_tag_reg.cell_idx])
            old_entry = '0;
        else if (lw_valid_reg && lw_cell_reg == w_tag_reg.cell_idx)
            old_entry = lw_data_reg;
        else
            old_entry = rdata;
        new_entry = {old_entry[ENTRY_W-1:COUNT_W] + SUM_W'(w_scaled_reg),
                     old_entry[COUNT_W-1:0] + 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= w_write;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_cell_reg <= w_tag_reg.cell_idx;
        lw_data_reg <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg <= '0;
        end
        else if (cfg_wr || fl_done)
        begin
            cvld_reg <= '0;
        end
        else if (w_valid_reg)
        begin
            if (w_tag_reg.clear)
            begin
                cvld_reg <= '0;
                if (w_write) cvld_reg[w_tag_reg.cell_idx] <= 1'b1;
            end
            else if (w_write)
            begin
                cvld_reg[w_tag_reg.cell_idx] <= 1'b1;
            end
        end
    end

    // ---------------- band flush
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:  if (w_valid_reg && w_tag_reg.band_end) state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == 4'd15) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg) state_next = (fidx_reg == CELL_LAST) ? ST_RUN
                                                                             : ST_READ;
            default: state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        fl_read = 1'b0;
        fl_load = 1'b0;
        fl_step = 1'b0;
        fl_out  = 1'b0;
        fl_done = 1'b0;
        unique case (state_reg)
            ST_RUN:  fl_read = 1'b0;
            ST_READ: fl_read = 1'b1;
            ST_LOAD: fl_load = 1'b1;
            ST_DIV:  fl_step = 1'b1;
            ST_OUT:
            begin
                fl_out  = !out_valid_reg;
                fl_done = !out_valid_reg && fidx_reg == CELL_LAST;
            end
            default: fl_read = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_RUN;
        else        state_reg <= state_next;
    end

    assign fl_entry = cvld_reg[fidx_reg] ? rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fidx_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (fl_out) fidx_reg <= fidx_reg + 1'b1;
            if (fl_load)      dcnt_reg <= '0;
            else if (fl_step) dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN && w_valid_reg && w_tag_reg.band_end)
        begin
            fband_reg <= w_tag_reg.band;
            flast_reg <= w_tag_reg.last_row;
        end
        if (fl_load)
        begin
            rem_reg <= fl_entry[ENTRY_W-1:COUNT_W];
            den_reg <= {fl_entry[COUNT_W-1:0], 15'd0};
            nz_reg  <= fl_entry[COUNT_W-1:0] != '0;
            quo_reg <= '0;
        end
        else if (fl_step)
        begin
            // quotient fits 16 bits: each sample is below 2^16
            if (rem_reg >= SUM_W'(den_reg))
            begin
                rem_reg <= rem_reg - SUM_W'(den_reg);
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            den_reg <= den_reg >> 1;
        end
        if (fl_out)
        begin
            out_reg.cell_column <= fidx_reg;
            out_reg.cell_row    <= fband_reg;
            out_reg.mean_luma   <= nz_reg ? quo_reg : 16'd0;
            out_reg.cell_valid  <= nz_reg;
            out_reg.band_last   <= fidx_reg == CELL_LAST;
            out_reg.frame_last  <= (fidx_reg == CELL_LAST) && flast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                     out_valid_reg <= 1'b0;
        else if (fl_out)                out_valid_reg <= 1'b1;
        else if (stats_ready)           out_valid_reg <= 1'b0;
    end

    assign stats_valid = out_valid_reg;
    assign stats       = out_reg;

    // ---------------- checks
    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> !pixel_ready)
        else $error("pixel taken during band flush");

    a_pipe_empty_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> !w_valid_reg && !p_valid)
        else $error("pixel in flight during band flush");

    a_band_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && w_valid_reg && w_tag_reg.band_end) |=> state_reg == ST_READ)
        else $error("band end did not start flush");

endmodule
